// ----- hdl/rps_pkg.sv -----
`timescale 1ns / 1ps

package rps_pkg;

    // Field widths fixed by the stream format.
    localparam int WORD_W    = 16;
    localparam int COUNT_W   = 7;
    localparam int ENTRY_W   = 6;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int M_PAD_W   = M_TDATA_W - 2 * ENTRY_W - 1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd64;

    // Transaction kinds carried on s_tuser.
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    typedef logic [WORD_W-1:0] word_t;

endpackage

// ----- hdl/random_permutation_shuffler.sv -----
`timescale 1ns / 1ps

// Channel   Direction  Signals                     Contents
// s_        in         s_tvalid/s_tready/s_tdata   rand_word; s_tuser = op
// m_        out        m_tvalid/m_tready/m_tdata   entry_index, entry_value, changed; m_tlast
// cfg_      in         cfg_we/cfg_wdata            element_count
//
// A start transaction fills the n table entries with the identity at one entry per cycle
// through the single write port. A step runs the remainder unit, then one table read and
// up to two table writes for the swap. The final step then emits n transactions, each
// after its own registered table read (ST_EMIT_RD, then ST_EMIT_LD).
// aresetn is synchronous, active low; the table itself is not cleared by reset.
// s_tready is low while a transaction is being worked; a stalled m_ side holds the emit.
module random_permutation_shuffler #(
    parameter int MAX_COUNT = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [rps_pkg::S_TDATA_W-1:0]     s_tdata,   // [15:0] rand_word
    input  logic [0:0]                        s_tuser,   // [0] op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rps_pkg::M_TDATA_W-1:0]     m_tdata,   // [5:0] entry_index, [11:6] entry_value,
                                                         // [12] changed, [15:13] zero
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [rps_pkg::COUNT_W-1:0]       cfg_wdata  // [6:0] element_count
);

    localparam int IDX_W = $clog2(MAX_COUNT);
    localparam int LEN_W = $clog2(MAX_COUNT + 1);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_FILL    = 3'd1;
    localparam logic [2:0] ST_DIV     = 3'd2;
    localparam logic [2:0] ST_READ    = 3'd3;
    localparam logic [2:0] ST_SWAP_A  = 3'd4;
    localparam logic [2:0] ST_SWAP_B  = 3'd5;
    localparam logic [2:0] ST_EMIT_RD = 3'd6;
    localparam logic [2:0] ST_EMIT_LD = 3'd7;

    logic [2:0]                       st_reg, st_next;
    logic [rps_pkg::COUNT_W-1:0]      count_reg, count_next;
    logic [LEN_W-1:0]                 len_reg, len_next;
    logic [LEN_W-1:0]                 pos_reg, pos_next;
    logic                             swap_reg, swap_next;
    logic [IDX_W-1:0]                 pick_reg, pick_next;
    logic [IDX_W-1:0]                 cnt_reg, cnt_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [rps_pkg::M_TDATA_W-1:0]    m_tdata_reg, m_tdata_next;
    logic                             m_tlast_reg, m_tlast_next;

    logic [LEN_W-1:0]                 clamped_len;
    logic                             s_fire;
    logic                             div_start;
    logic                             div_done;
    logic [LEN_W-1:0]                 div_rem;
    logic                             out_free;
    logic                             is_last;

    logic                             tbl_we;
    logic [IDX_W-1:0]                 tbl_waddr;
    logic [IDX_W-1:0]                 tbl_wdata;
    logic                             tbl_re;
    logic [IDX_W-1:0]                 tbl_raddr_a;
    logic [IDX_W-1:0]                 tbl_raddr_b;
    logic [IDX_W-1:0]                 tbl_rdata_a;
    logic [IDX_W-1:0]                 tbl_rdata_b;

    assign s_tready  = (st_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign div_start = s_fire && (s_tuser[0] == rps_pkg::OP_STEP) && (pos_reg != '0);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign is_last   = ({{(LEN_W - IDX_W){1'b0}}, cnt_reg} == (len_reg - 1'b1));

    // A zero count runs as one element; counts past the table depth saturate.
    always_comb begin
        if (count_reg == '0) begin
            clamped_len = LEN_W'(1);
        end else if (count_reg > rps_pkg::COUNT_W'(MAX_COUNT)) begin
            clamped_len = LEN_W'(MAX_COUNT);
        end else begin
            clamped_len = LEN_W'(count_reg);
        end
    end

    rps_div #(
        .DIV_W(LEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (s_tdata),
        .divisor  (pos_reg),
        .done     (div_done),
        .remainder(div_rem)
    );

    rps_table #(
        .DEPTH (MAX_COUNT),
        .DATA_W(IDX_W)
    ) u_table (
        .aclk   (aclk),
        .we     (tbl_we),
        .waddr  (tbl_waddr),
        .wdata  (tbl_wdata),
        .re     (tbl_re),
        .raddr_a(tbl_raddr_a),
        .raddr_b(tbl_raddr_b),
        .rdata_a(tbl_rdata_a),
        .rdata_b(tbl_rdata_b)
    );

    always_comb begin
        st_next       = st_reg;
        count_next    = cfg_we ? cfg_wdata : count_reg;
        len_next      = len_reg;
        pos_next      = pos_reg;
        swap_next     = swap_reg;
        pick_next     = pick_reg;
        cnt_next      = cnt_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        tbl_we      = 1'b0;
        tbl_waddr   = cnt_reg;
        tbl_wdata   = cnt_reg;
        tbl_re      = 1'b0;
        tbl_raddr_a = (st_reg == ST_READ) ? pick_reg : cnt_reg;
        tbl_raddr_b = pos_reg[IDX_W-1:0];

        unique case (st_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (s_tuser[0] == rps_pkg::OP_START) begin
                        len_next  = clamped_len;
                        pos_next  = clamped_len;
                        swap_next = 1'b0;
                        cnt_next  = '0;
                        st_next   = ST_FILL;
                    end else if (pos_reg != '0) begin
                        st_next = ST_DIV;
                    end
                end
            end
            ST_FILL: begin
                tbl_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (is_last) begin
                    st_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    pick_next = div_rem[IDX_W-1:0];
                    pos_next  = pos_reg - 1'b1;
                    st_next   = ST_READ;
                end
            end
            ST_READ: begin
                tbl_re  = 1'b1;
                st_next = ST_SWAP_A;
            end
            ST_SWAP_A: begin
                if ({{(LEN_W - IDX_W){1'b0}}, pick_reg} != pos_reg) begin
                    tbl_we    = 1'b1;
                    tbl_waddr = pick_reg;
                    tbl_wdata = tbl_rdata_b;
                    swap_next = 1'b1;
                    st_next   = ST_SWAP_B;
                end else if (pos_reg == '0) begin
                    cnt_next = '0;
                    st_next  = ST_EMIT_RD;
                end else begin
                    st_next = ST_IDLE;
                end
            end
            ST_SWAP_B: begin
                tbl_we    = 1'b1;
                tbl_waddr = pos_reg[IDX_W-1:0];
                tbl_wdata = tbl_rdata_a;
                if (pos_reg == '0) begin
                    cnt_next = '0;
                    st_next  = ST_EMIT_RD;
                end else begin
                    st_next = ST_IDLE;
                end
            end
            ST_EMIT_RD: begin
                // Read only once the output register is sure to be empty next cycle.
                if (out_free) begin
                    tbl_re  = 1'b1;
                    st_next = ST_EMIT_LD;
                end
            end
            ST_EMIT_LD: begin
                m_tvalid_next = 1'b1;
                m_tdata_next  = {{rps_pkg::M_PAD_W{1'b0}}, swap_reg,
                                 rps_pkg::ENTRY_W'(tbl_rdata_a),
                                 rps_pkg::ENTRY_W'(cnt_reg)};
                m_tlast_next  = is_last;
                cnt_next      = cnt_reg + 1'b1;
                st_next       = is_last ? ST_IDLE : ST_EMIT_RD;
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            count_reg    <= rps_pkg::COUNT_RESET;
            len_reg      <= '0;
            pos_reg      <= '0;
            swap_reg     <= 1'b0;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            st_reg       <= st_next;
            count_reg    <= count_next;
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            swap_reg     <= swap_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        pick_reg    <= pick_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

// ----- hdl/rps_div.sv -----
`timescale 1ns / 1ps

// Restoring remainder unit: one dividend bit per cycle, over all WORD_W dividend bits.
module rps_div #(
    parameter int DIV_W = 7
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  rps_pkg::word_t       dividend,
    input  logic [DIV_W-1:0]     divisor,
    output logic                 done,
    output logic [DIV_W-1:0]     remainder
);

    localparam int CNT_W = $clog2(rps_pkg::WORD_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    rps_pkg::word_t       quo_reg, quo_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     div_reg, div_next;
    logic [DIV_W:0]       trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, quo_reg[rps_pkg::WORD_W-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(rps_pkg::WORD_W);
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end else if (busy_reg) begin
            // The partial remainder stays below the divisor, so one subtract restores it.
            if (trial >= {1'b0, div_reg}) begin
                rem_next = DIV_W'(trial - {1'b0, div_reg});
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            quo_next = {quo_reg[rps_pkg::WORD_W-2:0], 1'b0};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// ----- hdl/rps_table.sv -----
`timescale 1ns / 1ps

// Order table: one write port, two read ports with registered data.
module rps_table #(
    parameter int DEPTH  = 64,
    parameter int DATA_W = 6
) (
    input  logic                         aclk,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic [DATA_W-1:0]            wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr_a,
    input  logic [$clog2(DEPTH)-1:0]     raddr_b,
    output logic [DATA_W-1:0]            rdata_a,
    output logic [DATA_W-1:0]            rdata_b
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a_reg <= mem_reg[raddr_a];
            rdata_b_reg <= mem_reg[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- dv/shuffle_checker.sv -----
`timescale 1ns / 1ps

module shuffle_checker #(
    parameter int MAX_COUNT = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [rps_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [0:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [rps_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [rps_pkg::COUNT_W-1:0]   cfg_wdata,
    output int                            failures,
    output int                            pending,
    output int                            entries_checked
);

    typedef struct packed {
        logic [rps_pkg::ENTRY_W-1:0] index;
        logic [rps_pkg::ENTRY_W-1:0] value;
        logic                        changed;
        logic                        last;
    } perm_entry_t;

    perm_entry_t                 expected_entries[$];
    logic [rps_pkg::ENTRY_W-1:0] order_copy[MAX_COUNT];
    logic [rps_pkg::COUNT_W-1:0] count_reg   = rps_pkg::COUNT_RESET;
    logic [rps_pkg::COUNT_W-1:0] steps_left  = '0;
    logic [rps_pkg::COUNT_W-1:0] run_len     = '0;
    logic                        moved       = 1'b0;
    int                          fail_count  = 0;
    int                          entry_count = 0;

    assign failures        = fail_count;
    assign entries_checked = entry_count;
    initial pending = 0;

    // Mirrors one accepted input transaction and queues the entries it releases.
    task automatic shuffle_item(input logic op, input rps_pkg::word_t word);
        int                          k;
        int                          pick;
        logic [rps_pkg::ENTRY_W-1:0] held;
        perm_entry_t                 item;
        if (op == rps_pkg::OP_START) begin
            if (count_reg == 0)
                run_len = 1;
            else if (count_reg > MAX_COUNT)
                run_len = MAX_COUNT;
            else
                run_len = count_reg;
            for (k = 0; k < run_len; k++) order_copy[k] = k[rps_pkg::ENTRY_W-1:0];
            steps_left = run_len;
            moved = 1'b0;
        end else if (steps_left != 0) begin
            pick = int'(word) % int'(steps_left);
            steps_left = steps_left - 1'b1;
            if (int'(steps_left) != pick) begin
                held = order_copy[pick];
                order_copy[pick] = order_copy[steps_left];
                order_copy[steps_left] = held;
                moved = 1'b1;
            end
            if (steps_left == 0) begin
                for (k = 0; k < run_len; k++) begin
                    item.index   = k[rps_pkg::ENTRY_W-1:0];
                    item.value   = order_copy[k];
                    item.changed = moved;
                    item.last    = (k + 1 == int'(run_len));
                    expected_entries.push_back(item);
                end
            end
        end
    endtask

    always @(posedge aclk) begin
        perm_entry_t want;
        perm_entry_t got;
        if (!aresetn) begin
            count_reg  = rps_pkg::COUNT_RESET;
            steps_left = '0;
            run_len    = '0;
            moved      = 1'b0;
            expected_entries.delete();
        end else begin
            if (cfg_we)
                count_reg = cfg_wdata;
            if (s_tvalid && s_tready)
                shuffle_item(s_tuser[0], s_tdata);
            if (m_tvalid && m_tready) begin
                got.index   = m_tdata[rps_pkg::ENTRY_W-1:0];
                got.value   = m_tdata[2*rps_pkg::ENTRY_W-1:rps_pkg::ENTRY_W];
                got.changed = m_tdata[2*rps_pkg::ENTRY_W];
                got.last    = m_tlast;
                if (expected_entries.size() == 0) begin
                    $error("unexpected permutation entry: index %0d value %0d",
                           got.index, got.value);
                    fail_count++;
                end else begin
                    want = expected_entries.pop_front();
                    entry_count++;
                    if (got.index !== want.index) begin
                        $error("entry_index mismatch: expected %0d, actual %0d",
                               want.index, got.index);
                        fail_count++;
                    end
                    if (got.value !== want.value) begin
                        $error("entry_value mismatch: expected %0d, actual %0d",
                               want.value, got.value);
                        fail_count++;
                    end
                    if (got.changed !== want.changed) begin
                        $error("changed mismatch: expected %0d, actual %0d",
                               want.changed, got.changed);
                        fail_count++;
                    end
                    if (got.last !== want.last) begin
                        $error("last mismatch: expected %0d, actual %0d",
                               want.last, got.last);
                        fail_count++;
                    end
                end
            end
        end
        pending <= expected_entries.size();
    end

endmodule

// ----- dv/random_permutation_shuffler_tb.sv -----
`timescale 1ns / 1ps

module random_permutation_shuffler_tb;

    localparam int MAX_COUNT     = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 150;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 108;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [rps_pkg::S_TDATA_W-1:0]   s_tdata   = '0;
    logic [0:0]                      s_tuser   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [rps_pkg::M_TDATA_W-1:0]   m_tdata;
    logic                            m_tlast;
    logic                            cfg_we    = 1'b0;
    logic [rps_pkg::COUNT_W-1:0]     cfg_wdata = '0;

    int   failures;
    int   pending;
    int   entries_checked;

    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic hold_toggle    = 1'b0;
    logic hold_seen      = 1'b0;
    int   hold_left      = 0;
    int   cycle_count    = 0;
    int   active_len     = MAX_COUNT;
    int   starts_sent    = 0;
    int   steps_sent     = 0;
    int   random_sent    = 0;

    random_permutation_shuffler #(
        .MAX_COUNT(MAX_COUNT)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    shuffle_checker #(
        .MAX_COUNT(MAX_COUNT)
    ) checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .failures       (failures),
        .pending        (pending),
        .entries_checked(entries_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Output side: random stalls, plus a long hold each time hold_toggle flips.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left <= 0;
            hold_seen <= hold_toggle;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready  <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic op, input rps_pkg::word_t word);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        if (op == rps_pkg::OP_START)
            starts_sent++;
        else
            steps_sent++;
        random_sent++;
    endtask

    // Waits until every expected entry has been seen and the block has gone quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_count(input logic [rps_pkg::COUNT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        if (value == 0)
            active_len = 1;
        else if (value > MAX_COUNT)
            active_len = MAX_COUNT;
        else
            active_len = value;
    endtask

    // A word that lands on the top slot leaves the order untouched.
    function automatic rps_pkg::word_t step_word(input int slots, input bit keep_order);
        if (keep_order)
            return rps_pkg::word_t'((slots - 1) +
                                    slots * $urandom_range((65535 - (slots - 1)) / slots));
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return rps_pkg::word_t'($urandom_range(65535));
        endcase
    endfunction

    task automatic run_shuffle(input int steps, input bit keep_order, input int hold_at);
        int i;
        send_item(rps_pkg::OP_START, rps_pkg::word_t'($urandom_range(65535)));
        for (i = 0; i < steps; i++) begin
            if (i == hold_at)
                hold_toggle <= ~hold_toggle;
            send_item(rps_pkg::OP_STEP, step_word(active_len - i, keep_order));
        end
    endtask

    initial begin
        int  n;
        int  steps;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: idle step, reset count, restart, counts 1, 0, 2 and 3.
        send_item(rps_pkg::OP_STEP, 16'hFFFF);
        send_item(rps_pkg::OP_START, 16'h0000);
        send_item(rps_pkg::OP_STEP, 16'h0000);
        send_item(rps_pkg::OP_STEP, 16'hFFFF);
        send_item(rps_pkg::OP_STEP, 16'h1234);
        settle();
        write_count(7'd1);
        send_item(rps_pkg::OP_START, 16'hFFFF);
        send_item(rps_pkg::OP_STEP, 16'hFFFF);
        send_item(rps_pkg::OP_STEP, 16'h0000);
        settle();
        write_count(7'd0);
        send_item(rps_pkg::OP_START, 16'h5A5A);
        send_item(rps_pkg::OP_STEP, 16'h0000);
        settle();
        write_count(7'd2);
        send_item(rps_pkg::OP_START, 16'h0000);
        send_item(rps_pkg::OP_STEP, 16'hFFFF);
        send_item(rps_pkg::OP_STEP, 16'h0000);
        send_item(rps_pkg::OP_START, 16'h0000);
        send_item(rps_pkg::OP_STEP, 16'h0000);
        send_item(rps_pkg::OP_STEP, 16'hFFFF);
        settle();
        write_count(7'd3);
        send_item(rps_pkg::OP_START, 16'h0000);
        send_item(rps_pkg::OP_STEP, 16'hAAAA);
        send_item(rps_pkg::OP_START, 16'h0000);
        send_item(rps_pkg::OP_STEP, 16'h5555);
        send_item(rps_pkg::OP_STEP, 16'hFFFF);
        send_item(rps_pkg::OP_STEP, 16'h0000);
        settle();
        random_sent = 0;

        // Back-to-back traffic on small tables.
        write_count(7'($urandom_range(9, 4)));
        repeat (2) run_shuffle(active_len, $urandom_range(4) == 0, -1);
        settle();

        send_idle_pct = 85;
        write_count(7'($urandom_range(8, 2)));
        repeat (2) run_shuffle(active_len, $urandom_range(4) == 0, -1);
        settle();

        // Saturated count; the output is held near the end so the input backs up
        // behind the emit, including a new start that is then left unfinished.
        send_idle_pct  = 0;
        recv_stall_pct = 85;
        write_count(7'd127);
        run_shuffle(active_len, 1'b0, active_len - 4);
        run_shuffle(3, 1'b0, -1);
        settle();

        send_idle_pct  = 30;
        recv_stall_pct = 30;
        while (random_sent < RANDOM_ITEMS) begin
            case ($urandom_range(3))
                0:       n = 0;
                1:       n = 1;
                default: n = $urandom_range(16, 2);
            endcase
            write_count(7'(n));
            repeat (3) begin
                if ($urandom_range(4) == 0)
                    send_item(rps_pkg::OP_STEP, rps_pkg::word_t'($urandom_range(65535)));
                steps = active_len;
                if ($urandom_range(4) == 0)
                    steps = $urandom_range(active_len - 1);
                run_shuffle(steps, $urandom_range(5) == 0, -1);
            end
            settle();
        end

        $display("Shuffle run: %0d starts and %0d steps over counts 0 to 16, 64 and 127,",
                 starts_sent, steps_sent);
        $display("with gaps, stalls and a long output hold; %0d entries compared.",
                 entries_checked);
        if (failures == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/rps_pkg.sv
hdl/rps_div.sv
hdl/rps_table.sv
hdl/random_permutation_shuffler.sv
dv/shuffle_checker.sv
dv/random_permutation_shuffler_tb.sv
